/* hw/rtl/rme_pkg.sv */
// ----------------------------------------------------------------------------
// rme_pkg
// shared constants and types for the modular exponentiation block
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int MOD_WIDTH_DEF = 32;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;

    localparam logic [1:0] REG_PUBLIC_EXP  = 2'd0;
    localparam logic [1:0] REG_PRIVATE_EXP = 2'd1;
    localparam logic [1:0] REG_MODULUS     = 2'd2;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

/* hw/rtl/rme_req_if.sv */
// ----------------------------------------------------------------------------
// rme_req_if
// request channel: command and word to exponentiate
// ----------------------------------------------------------------------------
interface rme_req_if;
    import rme_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [DATA_WIDTH-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);

endinterface

/* hw/rtl/rme_rsp_if.sv */
// ----------------------------------------------------------------------------
// rme_rsp_if
// response channel: exponentiation result
// ----------------------------------------------------------------------------
interface rme_rsp_if;
    import rme_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);

endinterface

/* hw/rtl/rme_cfg.sv */
// ----------------------------------------------------------------------------
// rme_cfg
// apb register file: public exponent, private exponent, modulus
// ----------------------------------------------------------------------------
module rme_cfg
    import rme_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    output logic [DATA_WIDTH-1:0] public_exp,
    output logic [DATA_WIDTH-1:0] private_exp,
    output logic [MOD_WIDTH-1:0]  modulus
);

    logic [DATA_WIDTH-1:0] pub_reg;
    logic [DATA_WIDTH-1:0] priv_reg;
    logic [MOD_WIDTH-1:0]  mod_reg;
    logic [1:0]            index;
    logic                  wr_en;

    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pub_reg  <= DATA_WIDTH'(1);
            priv_reg <= DATA_WIDTH'(1);
            mod_reg  <= MOD_WIDTH'(1);
        end
        else if (wr_en)
        begin
            case (index)
                REG_PUBLIC_EXP:  pub_reg  <= pwdata[DATA_WIDTH-1:0];
                REG_PRIVATE_EXP: priv_reg <= pwdata[DATA_WIDTH-1:0];
                REG_MODULUS:     mod_reg  <= pwdata[MOD_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_PUBLIC_EXP:  prdata = APB_DW'(pub_reg);
            REG_PRIVATE_EXP: prdata = APB_DW'(priv_reg);
            REG_MODULUS:     prdata = APB_DW'(mod_reg);
            default:         prdata = '0;
        endcase
    end

    assign public_exp  = pub_reg;
    assign private_exp = priv_reg;
    assign modulus     = mod_reg;

endmodule

/* hw/rtl/rme_modmul.sv */
// ----------------------------------------------------------------------------
// rme_modmul
// bit-serial modular multiplier: a * b mod m, double and add per bit of a
// ----------------------------------------------------------------------------
module rme_modmul
    import rme_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [MOD_WIDTH-1:0]  b,
    input  logic [MOD_WIDTH-1:0]  m,
    output mm_status_t            status,
    output logic [MOD_WIDTH-1:0]  r
);

    localparam int CW = $clog2(DATA_WIDTH);
    localparam logic [CW-1:0] LAST_BIT = CW'(DATA_WIDTH - 1);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic                  phase_reg, phase_next;
    logic [CW-1:0]         cnt_reg,   cnt_next;
    logic [DATA_WIDTH-1:0] a_reg,     a_next;
    logic [MOD_WIDTH-1:0]  b_reg,     b_next;
    logic [MOD_WIDTH-1:0]  r_reg,     r_next;

    logic [MOD_WIDTH-1:0]  addend;
    logic [MOD_WIDTH:0]    sum;
    logic [MOD_WIDTH:0]    reduced;

    // shared adder: doubling in phase 0, conditional add of b in phase 1
    assign addend  = phase_reg ? b_reg : r_reg;
    assign sum     = {1'b0, r_reg} + {1'b0, addend};
    assign reduced = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = '0;
            a_next     = a;
            b_next     = b;
            r_next     = '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                r_next     = reduced[MOD_WIDTH-1:0];
                phase_next = 1'b1;
            end
            else
            begin
                if (a_reg[DATA_WIDTH-1])
                begin
                    r_next = reduced[MOD_WIDTH-1:0];
                end
                a_next     = {a_reg[DATA_WIDTH-2:0], 1'b0};
                phase_next = 1'b0;
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == LAST_BIT)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign r           = r_reg;

`ifndef SYNTH
    a_done_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < m))
        else $error("modmul result not reduced");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("modmul did not start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("modmul done while busy");
`endif

endmodule

/* hw/rtl/rsa_modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// right-to-left square-and-multiply modular exponentiation over one shared
// bit-serial modular multiplier
//
// request channel carries cmd (encrypt with the public exponent, decrypt
// with the private exponent) and a 32-bit value; the response channel
// returns one result per request transaction: value ^ exponent mod modulus.
// the user must write exponents and the modulus over apb only while no
// transaction is in flight; the block itself does not enforce this.
// reads return the stored values. every modular multiplication runs
// in the shared multiplier, a doubling and an add phase per bit of a
// 32-bit operand, and reports done through a registered flag.
// an item costs one reduction of value, one squaring per exponent bit below
// the highest and one multiply per set bit; a zero exponent costs the
// reduction only, and a modulus of zero bypasses the multiplier.
// the request channel is ready only while the sequencer is idle.
// a finished result sits in the response register; a stalled receiver
// holds the next result in the sequencer until the register frees up.
// reset restores exponents and modulus to 1 and clears all control state.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation
    import rme_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    rme_req_if.sink           request,
    rme_rsp_if.source         response,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_SQR    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [DATA_WIDTH-1:0] public_exp;
    logic [DATA_WIDTH-1:0] private_exp;
    logic [MOD_WIDTH-1:0]  modulus;

    logic [2:0]            state_reg,  state_next;
    logic [DATA_WIDTH-1:0] exp_reg,    exp_next;
    logic [MOD_WIDTH-1:0]  acc_reg,    acc_next;
    logic [MOD_WIDTH-1:0]  base_reg,   base_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [DATA_WIDTH-1:0] rsp_result_reg, rsp_result_next;

    logic                  mm_start;
    logic [DATA_WIDTH-1:0] mm_a;
    logic [MOD_WIDTH-1:0]  mm_b;
    logic [MOD_WIDTH-1:0]  mm_r;
    mm_status_t            mm_st;

    logic                  req_take;
    logic                  rsp_take;
    logic                  rsp_free;
    logic [MOD_WIDTH-1:0]  one_mod;
    logic                  mod_zero;
    logic [DATA_WIDTH-1:0] exp_shift;

    rme_cfg #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .public_exp  (public_exp),
        .private_exp (private_exp),
        .modulus     (modulus)
    );

    rme_modmul #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .m      (modulus),
        .status (mm_st),
        .r      (mm_r)
    );

    assign request.ready   = (state_reg == S_IDLE);
    assign req_take        = request.valid && request.ready;
    assign rsp_take        = response.valid && response.ready;
    assign rsp_free        = !rsp_valid_reg || response.ready;
    assign mod_zero        = (modulus == '0);
    assign one_mod         = (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
    assign exp_shift       = exp_reg >> 1;
    assign response.valid  = rsp_valid_reg;
    assign response.result = rsp_result_reg;

    always_comb
    begin
        state_next      = state_reg;
        exp_next        = exp_reg;
        acc_next        = acc_reg;
        base_next       = base_reg;
        rsp_valid_next  = rsp_take ? 1'b0 : rsp_valid_reg;
        rsp_result_next = rsp_result_reg;
        mm_start        = 1'b0;
        mm_a            = DATA_WIDTH'(base_reg);
        mm_b            = base_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    exp_next = (request.cmd == CMD_DECRYPT) ? private_exp : public_exp;
                    if (mod_zero)
                    begin
                        acc_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        acc_next   = one_mod;
                        mm_start   = 1'b1;
                        mm_a       = request.value;
                        mm_b       = one_mod;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mm_st.done)
                begin
                    base_next  = mm_r;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_a       = DATA_WIDTH'(acc_reg);
                    state_next = S_MUL;
                end
                else
                begin
                    mm_start   = 1'b1;
                    exp_next   = exp_shift;
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (mm_st.done)
                begin
                    acc_next = mm_r;
                    exp_next = exp_shift;
                    if (exp_shift != '0)
                    begin
                        mm_start   = 1'b1;
                        state_next = S_SQR;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SQR:
            begin
                if (mm_st.done)
                begin
                    base_next  = mm_r;
                    state_next = S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_result_next = DATA_WIDTH'(acc_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg        <= exp_next;
        acc_reg        <= acc_next;
        base_reg       <= base_next;
        rsp_result_reg <= rsp_result_next;
    end

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_st.done |-> (state_reg == S_REDUCE || state_reg == S_MUL
                        || state_reg == S_SQR))
        else $error("multiplier done outside a wait state");
    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> !mm_st.busy)
        else $error("multiplier started while busy");
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && rsp_free) |=> (response.valid && state_reg == S_IDLE))
        else $error("result not loaded into response register");
    a_wait_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_SQR || state_reg == S_REDUCE)
        |-> (mm_st.busy || mm_st.done))
        else $error("waiting on an idle multiplier");
`endif

endmodule
